// File: sv/lsp_pkg.sv
package lsp_pkg;

  localparam int ADDR_W   = 16;
  localparam int FRAME_W  = 15;
  localparam int POS_W    = 40;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 24;
  localparam int DVD_W    = POS_W - FRAC_W;
  localparam int DVS_W    = 16;
  localparam int REM_CNT_W = $clog2(DVD_W);
  localparam logic [15:0] MAX_FRAMES = 16'd32768;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FRAME_COUNT   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_LOOP_ON       = 3'd2,
    REG_LOOP_FIRST    = 3'd3,
    REG_LOOP_LAST     = 3'd4,
    REG_STEP_SIZE     = 3'd5
  } reg_idx_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CHECK = 12'b0000_0000_0010,
    ST_WRAP  = 12'b0000_0000_0100,
    ST_DIV   = 12'b0000_0000_1000,
    ST_FIX   = 12'b0000_0001_0000,
    ST_RECHK = 12'b0000_0010_0000,
    ST_READ  = 12'b0000_0100_0000,
    ST_DRAIN = 12'b0000_1000_0000,
    ST_MIX   = 12'b0001_0000_0000,
    ST_MUL   = 12'b0010_0000_0000,
    ST_SUM   = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

endpackage

// File: sv/lsp_rem.sv
module lsp_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lsp_pkg::DVD_W-1:0]   dividend,
  input  logic [lsp_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [lsp_pkg::DVS_W-1:0]   remainder
);

  logic                            busy;
  logic [lsp_pkg::REM_CNT_W-1:0]   cnt;
  logic [lsp_pkg::DVD_W-1:0]       quo;
  logic [lsp_pkg::DVS_W-1:0]       dvs;
  logic [lsp_pkg::DVS_W:0]         trial;
  logic [lsp_pkg::DVS_W:0]         diff;

  // restoring remainder, one dividend bit per cycle
  assign trial = {remainder, quo[lsp_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lsp_pkg::REM_CNT_W'(lsp_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[lsp_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        remainder <= diff[lsp_pkg::DVS_W-1:0];
      end else begin
        remainder <= trial[lsp_pkg::DVS_W-1:0];
      end
    end
  end

endmodule

// File: sv/looped_sample_playback_top.sv
// Load and start words leave the sequencer idle, so ready stays high.
// A tick in range passes through check, recheck, read (two store reads, four with two channels),
// drain, mix, multiply, sum and output; a wrap into the loop adds the 24-step remainder unit.
// An inactive voice or an empty sample goes from check straight to output; so may a stopping tick.
// One word at a time; a finished result waits in the output register.
// Synchronous reset clears position, voice and registers; the sample store is not cleared.
module looped_sample_playback_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [15:0]        word_address,
  input  logic signed [15:0] word_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] audio_out,
  output logic               still_playing,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic [15:0] frame_count;
  logic [1:0]  channel_count;
  logic        loop_on;
  logic [14:0] loop_first;
  logic [15:0] loop_last;
  logic [23:0] step_size;

  lsp_pkg::state_t state;

  logic [lsp_pkg::POS_W-1:0]    pos;
  logic                         voice_on;
  logic [15:0]                  fc;
  logic [23:0]                  idx0_full;
  logic                         stereo;

  logic [15:0]                  loop_end;
  logic [15:0]                  len;
  logic                         wrap_dn;
  logic [15:0]                  lo;

  logic [lsp_pkg::POS_W-1:0]    s16;
  logic                         up;
  logic                         down;
  logic [lsp_pkg::POS_W-1:0]    sub_a;
  logic [lsp_pkg::POS_W-1:0]    sub_b;
  logic [lsp_pkg::POS_W-1:0]    sub_r;
  logic                         rem_start;
  logic                         rem_done;
  logic [15:0]                  rem;
  logic [31:0]                  r32;
  logic [31:0]                  fix_add;

  logic [14:0]                  idx0;
  logic [14:0]                  idx1;
  logic [15:0]                  nxt;
  logic [1:0]                   rd_cnt;
  logic [1:0]                   rd_last;
  logic                         rd_pend;
  logic [1:0]                   rd_tag;
  logic [14:0]                  rd_frame;
  logic [lsp_pkg::ADDR_W-1:0]   rd_addr;
  logic [15:0]                  rd_data;
  logic [15:0]                  words [4];
  logic [15:0]                  mem [2**lsp_pkg::ADDR_W];

  logic [16:0]                  sum0;
  logic [16:0]                  sum1;
  logic signed [15:0]           m0;
  logic signed [15:0]           m1;
  logic signed [15:0]           s0_r;
  logic signed [16:0]           diff_r;
  logic signed [33:0]           prod_r;
  logic signed [17:0]           val;
  logic [15:0]                  res_audio;
  logic                         res_play;
  logic                         out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == lsp_pkg::ST_IDLE);
  assign stereo    = channel_count[1];
  assign fc        = (frame_count > lsp_pkg::MAX_FRAMES) ? lsp_pkg::MAX_FRAMES : frame_count;
  assign idx0_full = pos[lsp_pkg::POS_W-1:lsp_pkg::FRAC_W];
  assign s16       = {9'd0, loop_first, 16'd0};
  assign out_load  = (state == lsp_pkg::ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      channel_count <= 2'd1;
      loop_on       <= 1'b0;
      loop_first    <= '0;
      loop_last     <= '0;
      step_size     <= 24'h010000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsp_pkg::REG_FRAME_COUNT:   frame_count   <= cfg_data[15:0];
        lsp_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        lsp_pkg::REG_LOOP_ON:       loop_on       <= cfg_data[0];
        lsp_pkg::REG_LOOP_FIRST:    loop_first    <= cfg_data[14:0];
        lsp_pkg::REG_LOOP_LAST:     loop_last     <= cfg_data[15:0];
        lsp_pkg::REG_STEP_SIZE:     step_size     <= cfg_data;
        default: ;
      endcase
    end
  end

  // wrap setup: one shared subtractor for both directions
  assign up    = pos >= {8'd0, loop_end, 16'd0};
  assign down  = pos < s16;
  assign sub_a = down ? s16 : pos;
  assign sub_b = down ? pos : s16;
  assign sub_r = sub_a - sub_b;

  assign rem_start = (state == lsp_pkg::ST_WRAP) && (up || down);

  lsp_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (sub_r[lsp_pkg::POS_W-1:lsp_pkg::FRAC_W]),
    .divisor   (len),
    .done      (rem_done),
    .remainder (rem)
  );

  assign r32     = {rem, lo};
  assign fix_add = !wrap_dn ? r32 : ((r32 == 32'd0) ? 32'd0 : ({len, 16'd0} - r32));

  assign idx0 = pos[lsp_pkg::FRAC_W+14:lsp_pkg::FRAC_W];
  assign nxt  = {1'b0, idx0} + 16'd1;

  assign rd_last  = stereo ? 2'd3 : 2'd1;
  assign rd_frame = (stereo ? rd_cnt[1] : rd_cnt[0]) ? idx1 : idx0;
  assign rd_addr  = stereo ? {rd_frame, rd_cnt[0]} : {1'b0, rd_frame};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && command == lsp_pkg::CMD_LOAD) begin
      mem[word_address] <= word_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == lsp_pkg::ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= rd_cnt;
    if (rd_pend) begin
      words[rd_tag] <= rd_data;
    end
  end

  assign sum0 = {words[0][15], words[0]} + {words[1][15], words[1]};
  assign sum1 = {words[2][15], words[2]} + {words[3][15], words[3]};
  assign m0   = stereo ? $signed(sum0[16:1]) : $signed(words[0]);
  assign m1   = stereo ? $signed(sum1[16:1]) : $signed(words[1]);
  assign val  = $signed({{2{s0_r[15]}}, s0_r}) + $signed(prod_r[33:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsp_pkg::ST_IDLE;
      pos       <= '0;
      voice_on  <= 1'b0;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lsp_pkg::ST_IDLE: begin
          if (in_valid) begin
            case (command)
              lsp_pkg::CMD_START: begin
                pos      <= '0;
                voice_on <= 1'b1;
              end
              lsp_pkg::CMD_TICK: state <= lsp_pkg::ST_CHECK;
              default: ;
            endcase
          end
        end
        lsp_pkg::ST_CHECK: begin
          loop_end <= (loop_last > {1'b0, loop_first}) ? loop_last : fc;
          len      <= ((loop_last > {1'b0, loop_first}) ? loop_last : fc) - {1'b0, loop_first};
          if (!voice_on) begin
            res_audio <= '0;
            res_play  <= 1'b0;
            state     <= lsp_pkg::ST_OUT;
          end else if (fc == 16'd0) begin
            res_audio <= '0;
            res_play  <= 1'b1;
            state     <= lsp_pkg::ST_OUT;
          end else if (idx0_full >= {8'd0, fc}) begin
            if (!loop_on || ((loop_last > {1'b0, loop_first}) ? loop_last : fc)
                            <= {1'b0, loop_first}) begin
              voice_on  <= 1'b0;
              res_audio <= '0;
              res_play  <= 1'b0;
              state     <= lsp_pkg::ST_OUT;
            end else begin
              state <= lsp_pkg::ST_WRAP;
            end
          end else begin
            state <= lsp_pkg::ST_RECHK;
          end
        end
        lsp_pkg::ST_WRAP: begin
          wrap_dn <= down && !up;
          lo      <= sub_r[15:0];
          state   <= (up || down) ? lsp_pkg::ST_DIV : lsp_pkg::ST_RECHK;
        end
        lsp_pkg::ST_DIV: begin
          if (rem_done) begin
            state <= lsp_pkg::ST_FIX;
          end
        end
        lsp_pkg::ST_FIX: begin
          pos   <= s16 + {8'd0, fix_add};
          state <= lsp_pkg::ST_RECHK;
        end
        lsp_pkg::ST_RECHK: begin
          rd_cnt <= '0;
          if (idx0_full >= {8'd0, fc}) begin
            voice_on  <= 1'b0;
            res_audio <= '0;
            res_play  <= 1'b0;
            state     <= lsp_pkg::ST_OUT;
          end else begin
            if (nxt >= fc) begin
              idx1 <= (loop_on && {1'b0, loop_first} < fc) ? loop_first : 15'(fc - 16'd1);
            end else begin
              idx1 <= nxt[14:0];
            end
            state <= lsp_pkg::ST_READ;
          end
        end
        lsp_pkg::ST_READ: begin
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == rd_last) begin
            state <= lsp_pkg::ST_DRAIN;
          end
        end
        lsp_pkg::ST_DRAIN: state <= lsp_pkg::ST_MIX;
        lsp_pkg::ST_MIX: begin
          s0_r   <= m0;
          diff_r <= 17'(m1) - 17'(m0);
          state  <= lsp_pkg::ST_MUL;
        end
        lsp_pkg::ST_MUL: begin
          prod_r <= 34'(diff_r) * 34'($signed({1'b0, pos[15:0]}));
          state  <= lsp_pkg::ST_SUM;
        end
        lsp_pkg::ST_SUM: begin
          res_audio <= val[15:0];
          res_play  <= 1'b1;
          pos       <= pos + {16'd0, step_size};
          state     <= lsp_pkg::ST_OUT;
        end
        lsp_pkg::ST_OUT: begin
          if (out_load) begin
            audio_out     <= res_audio;
            still_playing <= res_play;
            state         <= lsp_pkg::ST_IDLE;
          end
        end
        default: state <= lsp_pkg::ST_IDLE;
      endcase
    end
  end

  a_rem_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == lsp_pkg::ST_DIV)
    else $error("remainder finished outside wait state");

  a_div_loop: assert property (@(posedge clk) disable iff (rst)
    state == lsp_pkg::ST_DIV |-> voice_on && loop_on)
    else $error("wrap without active looping voice");

  a_play_flag: assert property (@(posedge clk) disable iff (rst)
    state == lsp_pkg::ST_OUT |-> res_play == voice_on)
    else $error("result flag disagrees with voice state");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == lsp_pkg::CMD_TICK |=> state != lsp_pkg::ST_IDLE)
    else $error("tick accepted but sequencer idle");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> state == lsp_pkg::ST_IDLE && $past(state) == lsp_pkg::ST_OUT)
    else $error("result word loaded outside output state");

endmodule

// File: bench/looped_sample_playback_top_tb.sv
`timescale 1ns / 1ps

module looped_sample_playback_top_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_WORDS = 2000;
  localparam int SCRIPT_ROWS = 33;

  typedef struct {
    bit [15:0] level;
    bit        playing;
  } tick_out_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    bit [2:0]  code;
    bit [15:0] addr;
    bit [23:0] data;
    bit        typed;
    bit [15:0] level;
    bit        playing;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         command;
  logic [15:0]        word_address;
  logic signed [15:0] word_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] audio_out;
  logic               still_playing;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;

  // voice model
  bit [15:0] sample_mem [65536];
  bit        mem_written [65536];
  bit [39:0] position_q;
  bit        voice_q;
  bit [15:0] frames_r;
  bit [1:0]  chans_r;
  bit        loop_r;
  bit [14:0] first_r;
  bit [15:0] last_r;
  bit [23:0] step_r;
  bit [15:0] tick_reads [4];
  int        read_count;

  tick_out_t due_samples [$];
  tick_out_t blank_out;
  int        errors;
  int        words_sent;
  int        cycle_count;
  bit        sender_idle;
  bit        reader_idle;

  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b1, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_START, 16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b1, 16'h0000, 1'b1},
    '{ROW_WORD, CMD_UNUSED,         16'hFFFF, 24'h00FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_FRAME_COUNT,   16'h0000, 24'd4, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_CHANNEL_COUNT, 16'h0000, 24'd2, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_STEP_SIZE, 16'h0000, 24'h00C000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0000, 24'h007FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0001, 24'h007FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0002, 24'h008000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0003, 24'h008000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0004, 24'h007FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0005, 24'h008000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0006, 24'h000001, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'h0007, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_LOAD,  16'hFFFF, 24'h001234, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_START, 16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_LOOP_ON,    16'h0000, 24'd1, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_LOOP_FIRST, 16'h0000, 24'd1, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_LOOP_LAST,  16'h0000, 24'd3, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG,  lsp_pkg::REG_STEP_SIZE, 16'h0000, 24'h018000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_START, 16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, lsp_pkg::CMD_TICK,  16'h0000, 24'h000000, 1'b0, 16'h0000, 1'b0}
  };

  looped_sample_playback_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .word_address  (word_address),
    .word_value    (word_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .audio_out     (audio_out),
    .still_playing (still_playing),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint frame_level(input longint unsigned f,
                                         input longint unsigned chans);
    longint unsigned base;
    longint          sum;
    base = f * chans;
    tick_reads[read_count] = 16'(base);
    read_count++;
    sum = longint'($signed(sample_mem[16'(base)]));
    if (chans == 2) begin
      tick_reads[read_count] = 16'(base + 1);
      read_count++;
      sum += longint'($signed(sample_mem[16'(base + 1)]));
      sum = sum >>> 1;
    end
    return sum;
  endfunction

  // one tick of the voice; with commit clear it changes no voice state and serves to collect the store reads
  function automatic void voice_tick(input bit commit, output bit [15:0] level,
                                     output bit playing);
    longint unsigned fc, pos, idx0, idx1, s, e, s16, len16, chans;
    longint          m0, m1, frac, val;
    bit              on, live;
    read_count = 0;
    level = '0;
    playing = 1'b0;
    pos = 64'(position_q);
    on = voice_q;
    fc = 64'((frames_r > lsp_pkg::MAX_FRAMES) ? lsp_pkg::MAX_FRAMES : frames_r);
    chans = chans_r[1] ? 2 : 1;
    if (on && fc == 0) begin
      playing = 1'b1;
    end else if (on) begin
      idx0 = pos >> 16;
      live = 1'b1;
      if (idx0 >= fc) begin
        s = 64'(first_r);
        e = (64'(last_r) > s) ? 64'(last_r) : fc;
        if (!loop_r || e <= s) begin
          live = 1'b0;
        end else begin
          s16 = s << 16;
          len16 = (e - s) << 16;
          if (pos >= (e << 16)) pos = s16 + (pos - s16) % len16;
          else if (pos < s16) pos = s16 + (len16 - (s16 - pos) % len16) % len16;
          idx0 = pos >> 16;
          live = (idx0 < fc);
        end
      end
      if (live) begin
        idx1 = idx0 + 1;
        if (idx1 >= fc) idx1 = (loop_r && 64'(first_r) < fc) ? 64'(first_r) : fc - 1;
        m0 = frame_level(idx0, chans);
        m1 = frame_level(idx1, chans);
        frac = longint'(pos & 64'hFFFF);
        val = m0 + (((m1 - m0) * frac) >>> 16);
        level = val[15:0];
        playing = 1'b1;
        pos = (pos + 64'(step_r)) & 64'hFF_FFFF_FFFF;
      end else begin
        on = 1'b0;
      end
    end
    if (commit) begin
      position_q = 40'(pos);
      voice_q = on;
    end
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [15:0] value, input bit typed,
                           input tick_out_t typed_out);
    int        gap;
    tick_out_t got;
    gap = sender_idle ? int'($urandom_range(0, 14)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    word_address <= addr;
    word_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd != CMD_UNUSED) words_sent++;
    case (cmd)
      lsp_pkg::CMD_LOAD: begin
        sample_mem[addr] = value;
        mem_written[addr] = 1'b1;
      end
      lsp_pkg::CMD_START: begin
        position_q = '0;
        voice_q = 1'b1;
      end
      lsp_pkg::CMD_TICK: begin
        voice_tick(1'b1, got.level, got.playing);
        due_samples.insert(due_samples.size(), typed ? typed_out : got);
      end
      default: ;
    endcase
  endtask

  // fill any store word the next tick would read before sending it
  task automatic play_tick();
    tick_out_t peek;
    int        n;
    voice_tick(1'b0, peek.level, peek.playing);
    n = read_count;
    for (int i = 0; i < n; i++) begin
      if (!mem_written[tick_reads[i]])
        send_word(lsp_pkg::CMD_LOAD, tick_reads[i], rand_word(), 1'b0, blank_out);
    end
    send_word(lsp_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 1'b0, blank_out);
  endtask

  task automatic write_reg(input lsp_pkg::reg_idx_t idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lsp_pkg::REG_FRAME_COUNT:   frames_r = data[15:0];
      lsp_pkg::REG_CHANNEL_COUNT: chans_r = data[1:0];
      lsp_pkg::REG_LOOP_ON:       loop_r = data[0];
      lsp_pkg::REG_LOOP_FIRST:    first_r = data[14:0];
      lsp_pkg::REG_LOOP_LAST:     last_r = data[15:0];
      lsp_pkg::REG_STEP_SIZE:     step_r = data;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    int unsigned fc, fc_eff, first, last;
    settle();
    case ($urandom_range(0, 9))
      0: fc = 0;
      1: fc = 32768;
      2: fc = 65535;
      3: fc = 32767;
      4: fc = $urandom_range(0, 65535);
      default: fc = $urandom_range(1, 48);
    endcase
    fc_eff = (fc > 32'(lsp_pkg::MAX_FRAMES)) ? 32'(lsp_pkg::MAX_FRAMES) : fc;
    case ($urandom_range(0, 7))
      0: first = 0;
      1: first = 32767;
      2: first = $urandom_range(0, 32767);
      default: first = (fc_eff > 1) ? $urandom_range(0, fc_eff - 1) : 0;
    endcase
    case ($urandom_range(0, 9))
      0: last = 0;
      1: last = 65535;
      2: last = 32768;
      3: last = $urandom_range(0, 65535);
      4: last = first;
      default: last = (fc_eff > first) ? $urandom_range(first + 1, fc_eff) : 0;
    endcase
    write_reg(lsp_pkg::REG_FRAME_COUNT, 24'(fc));
    write_reg(lsp_pkg::REG_CHANNEL_COUNT, 24'($urandom_range(0, 3)));
    write_reg(lsp_pkg::REG_LOOP_ON, 24'($urandom_range(0, 3) != 0));
    write_reg(lsp_pkg::REG_LOOP_FIRST, 24'(first));
    write_reg(lsp_pkg::REG_LOOP_LAST, 24'(last));
    case ($urandom_range(0, 7))
      0: write_reg(lsp_pkg::REG_STEP_SIZE, 24'h000000);
      1: write_reg(lsp_pkg::REG_STEP_SIZE, 24'hFFFFFF);
      2: write_reg(lsp_pkg::REG_STEP_SIZE, 24'($urandom));
      default: write_reg(lsp_pkg::REG_STEP_SIZE, 24'($urandom_range(32'h000800, 32'h030000)));
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tick_out_t want;
    int        stall;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (due_samples.size() == 0) begin
          $error("audio_out: word %0d arrived with no tick pending", audio_out);
          errors++;
        end else begin
          want = due_samples.pop_front();
          if (audio_out !== want.level) begin
            $error("audio_out: expected %0d, got %0d", $signed(want.level), audio_out);
            errors++;
          end
          if (still_playing !== want.playing) begin
            $error("still_playing: expected %0d, got %0d", want.playing, still_playing);
            errors++;
          end
        end
        stall = reader_idle ? int'($urandom_range(0, 14)) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    tick_out_t typed_out;
    bit        in_cfg;
    int        pick;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= lsp_pkg::CMD_LOAD;
    word_address <= '0;
    word_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= lsp_pkg::REG_FRAME_COUNT;
    cfg_data <= '0;
    channel_defaults: begin
      chans_r = 2'd1;
      step_r = 24'h010000;
    end
    sender_idle = 1'b1;
    reader_idle = 1'b1;
    in_cfg = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        if (!in_cfg) settle();
        write_reg(lsp_pkg::reg_idx_t'(script[i].code), script[i].data);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        typed_out.level = script[i].level;
        typed_out.playing = script[i].playing;
        send_word(script[i].code[1:0], script[i].addr, script[i].data[15:0],
                  script[i].typed, typed_out);
      end
    end

    while (words_sent < RANDOM_WORDS) begin
      random_setup();
      sender_idle = ($urandom_range(0, 3) != 0);
      reader_idle = ($urandom_range(0, 3) != 0);
      send_word(lsp_pkg::CMD_START, 16'($urandom), 16'($urandom), 1'b0, blank_out);
      repeat ($urandom_range(8, 60)) begin
        pick = int'($urandom_range(0, 19));
        if (pick == 0)
          send_word(lsp_pkg::CMD_LOAD, 16'($urandom), rand_word(), 1'b0, blank_out);
        else if (pick == 1)
          send_word(lsp_pkg::CMD_START, 16'($urandom), 16'($urandom), 1'b0, blank_out);
        else if (pick == 2)
          send_word(CMD_UNUSED, 16'($urandom), 16'($urandom), 1'b0, blank_out);
        else
          play_tick();
      end
    end

    settle();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
